// ===== rtl/fcob_pkg.sv =====
// Shared constants and types for the bracket-aware character scanner.
package fcob_pkg;

    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned MAX_LENGTH  = 65536;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CNT_W       = 2;

    // Saturation point of the byte index
    localparam int unsigned POS_LIMIT_INT =
        ((MAX_LENGTH - 1) < 65535) ? (MAX_LENGTH - 1) : 65535;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_INT);

    localparam logic [CHAR_W-1:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_PAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_BRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH   = 8'h5C;

    // Closer kind held in a stack cell
    localparam logic KIND_PAREN = 1'b0;
    localparam logic KIND_BRACE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_A     = 2'd0,
        CFG_TARGET_B     = 2'd1,
        CFG_TARGET_C     = 2'd2,
        CFG_TARGET_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctrl;

    typedef struct packed {
        logic top_valid;
        logic top_kind;
        logic full;
    } t_stk_stat;

    typedef struct packed {
        logic valid;
        logic kind;
    } t_cell_link;

endpackage

// ===== rtl/fcob_cell.sv =====
// One entry of the shifting closer stack.
module fcob_cell import fcob_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stk_ctrl  i_ctrl,
    input  t_cell_link i_upper,
    input  t_cell_link i_lower,
    output t_cell_link o_cell
);

    logic r_valid;
    logic r_kind;
    logic n_valid;
    logic n_kind;

    always_comb begin
        n_valid = r_valid;
        n_kind  = r_kind;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.push) begin
            n_valid = i_upper.valid;
            n_kind  = i_upper.kind;
        end else if (i_ctrl.pop) begin
            n_valid = i_lower.valid;
            n_kind  = i_lower.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.kind  = r_kind;

endmodule

// ===== rtl/fcob_stack.sv =====
// Row of stack cells; the top of stack is cell zero.
module fcob_stack import fcob_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stk_ctrl i_ctrl,
    input  logic      i_kind,
    output t_stk_stat o_stat
);

    t_cell_link             w_cell  [STACK_DEPTH];
    t_cell_link             w_upper [STACK_DEPTH];
    t_cell_link             w_lower [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_valid;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_top
            assign w_upper[g] = '{valid: 1'b1, kind: i_kind};
        end else begin : g_mid
            assign w_upper[g] = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_lower[g] = '{valid: 1'b0, kind: KIND_PAREN};
        end else begin : g_up
            assign w_lower[g] = w_cell[g+1];
        end

        fcob_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_upper (w_upper[g]),
            .i_lower (w_lower[g]),
            .o_cell  (w_cell[g])
        );

        assign w_valid[g] = w_cell[g].valid;
    end

    assign o_stat.top_valid = w_cell[0].valid;
    assign o_stat.top_kind  = w_cell[0].kind;
    assign o_stat.full      = w_cell[STACK_DEPTH-1].valid;

    // Occupied cells form an unbroken run from the top
    a_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("stack cells not contiguous");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push && !i_ctrl.clear |-> !o_stat.full)
        else $error("push onto full stack");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop && !i_ctrl.clear |-> o_stat.top_valid)
        else $error("pop from empty stack");

endmodule

// ===== rtl/find_char_outside_brackets.sv =====
// Top level: scans a byte stream for a target character outside brackets.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_char_in, i_last_char
//  result    out        o_valid / i_stall    o_found, o_position, o_overflowed
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One byte per clock unless stalled; stack top and escape flag are registered.
// A result is in the output register in the cycle after the byte that causes it.
// Input stalls only while a result waits and the sink stalls.
// Reset is synchronous and clears the stack, the per-string state and the targets.
module find_char_outside_brackets import fcob_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [CHAR_W-1:0]    i_char_in,
    input  logic                 i_last_char,
    output logic                 o_stall,
    output logic                 o_valid,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_overflowed,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CHAR_W-1:0] r_target_a;
    logic [CHAR_W-1:0] r_target_b;
    logic [CHAR_W-1:0] r_target_c;
    logic [CNT_W-1:0]  r_target_count;

    logic              r_esc;
    logic [POS_W-1:0]  r_idx;
    logic              r_reported;
    logic              r_ovf;

    logic              r_out_valid;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_ovf;

    logic              w_acc;
    logic              w_is_target;
    logic              w_hit;
    logic              w_scan;
    logic              w_open;
    logic              w_close;
    logic              w_kind;
    logic              w_push_req;
    logic              w_ovf_new;
    t_stk_ctrl         w_ctrl;
    t_stk_stat         w_stat;

    assign o_stall = r_out_valid & i_stall;
    assign w_acc   = i_valid & ~o_stall;

    always_comb begin
        w_is_target = (i_char_in == r_target_a)
                    | (r_target_count[1] & (i_char_in == r_target_b))
                    | ((r_target_count == 2'd3) & (i_char_in == r_target_c));
    end

    assign w_hit  = ~r_reported & w_is_target & ~w_stat.top_valid & ~r_esc;
    assign w_scan = ~r_reported & ~w_hit;

    assign w_open  = (i_char_in == CH_OPEN_PAREN) | (i_char_in == CH_OPEN_BRACE);
    assign w_close = (i_char_in == CH_CLOSE_PAREN) | (i_char_in == CH_CLOSE_BRACE);
    assign w_kind  = ((i_char_in == CH_OPEN_BRACE) | (i_char_in == CH_CLOSE_BRACE))
                   ? KIND_BRACE : KIND_PAREN;

    assign w_push_req   = w_acc & w_scan & w_open;
    assign w_ctrl.push  = w_push_req & ~w_stat.full;
    assign w_ctrl.pop   = w_acc & w_scan & w_close & w_stat.top_valid
                        & (w_stat.top_kind == w_kind);
    assign w_ctrl.clear = w_acc & i_last_char;
    assign w_ovf_new    = r_ovf | (w_push_req & w_stat.full);

    fcob_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_kind  (w_kind),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_a     <= '0;
            r_target_b     <= '0;
            r_target_c     <= '0;
            r_target_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_A:     r_target_a     <= i_cfg_data;
                CFG_TARGET_B:     r_target_b     <= i_cfg_data;
                CFG_TARGET_C:     r_target_c     <= i_cfg_data;
                CFG_TARGET_COUNT: r_target_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-string scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= 1'b0;
            r_idx      <= '0;
            r_reported <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (w_acc) begin
            if (i_last_char) begin
                r_esc      <= 1'b0;
                r_idx      <= '0;
                r_reported <= 1'b0;
                r_ovf      <= 1'b0;
            end else if (w_hit) begin
                r_reported <= 1'b1;
            end else if (w_scan) begin
                r_esc <= (i_char_in == CH_BACKSLASH) & ~r_esc;
                r_ovf <= w_ovf_new;
                if (r_idx < POS_LIMIT) begin
                    r_idx <= r_idx + POS_W'(1);
                end
            end
        end
    end

    // Output register; hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc & (w_hit | (w_scan & i_last_char))) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc & (w_hit | (w_scan & i_last_char))) begin
            r_out_found <= w_hit;
            r_out_pos   <= w_hit ? r_idx : '0;
            r_out_ovf   <= w_hit ? r_ovf : w_ovf_new;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_position   = r_out_pos;
    assign o_overflowed = r_out_ovf;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_last_char |=> !w_stat.top_valid && !r_esc && r_idx == '0 && !r_reported)
        else $error("string state not cleared at end of string");

    a_hit_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_hit && !i_last_char |=> r_reported && o_valid && o_found)
        else $error("hit not recorded");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_position == '0)
        else $error("not-found result with nonzero position");

    a_no_new_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> !w_acc)
        else $error("input taken while result held");

endmodule
